// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define CHK_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every clock edge, including during reset.
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/salwc_pkg.sv =====
// ----------------------------------------------------------------------------
// salwc_pkg
// Types and constants of the set-associative LRU write-back cache core.
// ----------------------------------------------------------------------------
package salwc_pkg;

   localparam int ADDR_W   = 64;
   localparam int CNT_W    = 48;
   localparam int CFG_W    = 4;
   localparam int NUM_CNT  = 6;

   // Configuration register indexes.
   localparam logic CSR_OFFSET_BITS = 1'b0;
   localparam logic CSR_INDEX_BITS  = 1'b1;

   localparam logic [CFG_W-1:0] OFFSET_BITS_RESET = 4'd5;
   localparam logic [CFG_W-1:0] INDEX_BITS_RESET  = 4'd7;

   // Event counter slots.
   localparam int CNT_ACCESS = 0;
   localparam int CNT_READ   = 1;
   localparam int CNT_WRITE  = 2;
   localparam int CNT_RMISS  = 3;
   localparam int CNT_WMISS  = 4;
   localparam int CNT_WB     = 5;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   // Access command codes.
   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   typedef struct packed {
      logic              cmd;
      logic [ADDR_W-1:0] address;
   } req_payload_type;

   typedef struct packed {
      logic             hit;
      logic [1:0]       way;
      logic             filled_empty;
      logic             write_back;
      logic [CNT_W-1:0] access_count;
      logic [CNT_W-1:0] read_count;
      logic [CNT_W-1:0] write_count;
      logic [CNT_W-1:0] read_miss_count;
      logic [CNT_W-1:0] write_miss_count;
      logic [CNT_W-1:0] write_back_count;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic clear_step;
      logic accept;
      logic update;
   } ctrl_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic clear_last;
      logic rsp_stall;
   } ctrl_status_type;

   // Saturating increment of an event counter.
   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] value,
                                                input logic             enable);
      logic [CNT_W-1:0] result;
      result = value;
      if (enable && (value != CNT_MAX)) begin
         result = value + CNT_W'(1);
      end
      return result;
   endfunction

endpackage

// ===== src/salwc_ram.sv =====
// ----------------------------------------------------------------------------
// salwc_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module salwc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/salwc_ctrl.sv =====
// ----------------------------------------------------------------------------
// salwc_ctrl
// Controller: clearing pass after reset, then accept and update per access.
// ----------------------------------------------------------------------------
module salwc_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  salwc_pkg::ctrl_status_type status,
   output salwc_pkg::ctrl_cmd_type    cmd
);

   salwc_pkg::state_type state_ff;
   salwc_pkg::state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= salwc_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      req_ready      = 1'b0;
      unique case (state_ff)
         salwc_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = salwc_pkg::ST_IDLE;
            end
         end
         salwc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = salwc_pkg::ST_UPDATE;
            end
         end
         salwc_pkg::ST_UPDATE: begin
            if (!status.rsp_stall) begin
               cmd.update = 1'b1;
               state_in   = salwc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = salwc_pkg::ST_CLEAR;
         end
      endcase
   end

endmodule

// ===== src/salwc_datapath.sv =====
// ----------------------------------------------------------------------------
// salwc_datapath
// Address split, tag and metadata stores, hit and victim logic, LRU update,
// event counters and the result register.
// ----------------------------------------------------------------------------
module salwc_datapath #(
   parameter int WAYS = 4,
   parameter int SETS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic                                csr_index,
   input  logic [salwc_pkg::CFG_W-1:0]         csr_wdata,
   input  salwc_pkg::req_payload_type          req_data,
   output salwc_pkg::rsp_payload_type          rsp_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  salwc_pkg::ctrl_cmd_type             cmd,
   output salwc_pkg::ctrl_status_type          status
);

   localparam int WW       = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int AW       = WW;
   localparam int SW       = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int MAXIB    = $clog2(SETS + 1) - 1;
   localparam int AWID     = salwc_pkg::ADDR_W;
   localparam int TAG_ROW  = WAYS * AWID;
   localparam int META_W   = 2 + AW;
   localparam int META_ROW = WAYS * META_W;
   localparam int CW       = salwc_pkg::CNT_W;

   // Configuration registers.
   logic [salwc_pkg::CFG_W-1:0] offset_ff;
   logic [salwc_pkg::CFG_W-1:0] index_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= salwc_pkg::OFFSET_BITS_RESET;
         index_ff  <= salwc_pkg::INDEX_BITS_RESET;
      end else if (csr_we) begin
         if (csr_index == salwc_pkg::CSR_OFFSET_BITS) begin
            offset_ff <= csr_wdata;
         end else begin
            index_ff <= csr_wdata;
         end
      end
   end

   // Address split at the input transfer.
   logic [4:0]      ib_eff;
   logic [AWID-1:0] shifted;
   logic [16:0]     set_mask;
   logic [SW-1:0]   set_idx;
   logic [5:0]      tag_shift;
   logic [AWID-1:0] tag_cur;

   always_comb begin
      ib_eff    = ({1'b0, index_ff} > 5'(MAXIB)) ? 5'(MAXIB) : {1'b0, index_ff};
      shifted   = req_data.address >> offset_ff;
      set_mask  = (17'(1) << ib_eff) - 17'(1);
      set_idx   = SW'(shifted) & SW'(set_mask);
      tag_shift = 6'(offset_ff) + 6'(ib_eff);
      tag_cur   = req_data.address >> tag_shift;
   end

   // Captured access.
   logic            cmd_ff;
   logic [SW-1:0]   set_ff;
   logic [AWID-1:0] tag_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cmd_ff <= req_data.cmd;
         set_ff <= set_idx;
         tag_ff <= tag_cur;
      end
   end

   // Clearing pass counter over the metadata store.
   logic [SW-1:0] clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_cnt_ff <= clr_cnt_ff + SW'(1);
      end
   end

   // Stores.
   logic [TAG_ROW-1:0]  tag_rd;
   logic [TAG_ROW-1:0]  tag_wr;
   logic [META_ROW-1:0] meta_rd;
   logic [META_ROW-1:0] meta_wr;
   logic [SW-1:0]       meta_waddr;
   logic [META_ROW-1:0] meta_wdata;

   assign meta_waddr = cmd.clear_step ? clr_cnt_ff : set_ff;
   assign meta_wdata = cmd.clear_step ? '0 : meta_wr;

   salwc_ram #(.WIDTH(TAG_ROW), .DEPTH(SETS)) u_tag_ram (
      .clock (clock),
      .we    (cmd.update),
      .waddr (set_ff),
      .wdata (tag_wr),
      .re    (cmd.accept),
      .raddr (set_idx),
      .rdata (tag_rd)
   );

   salwc_ram #(.WIDTH(META_ROW), .DEPTH(SETS)) u_meta_ram (
      .clock (clock),
      .we    (cmd.update | cmd.clear_step),
      .waddr (meta_waddr),
      .wdata (meta_wdata),
      .re    (cmd.accept),
      .raddr (set_idx),
      .rdata (meta_rd)
   );

   // Lookup, victim choice and LRU update.
   logic [WAYS-1:0]   vld;
   logic [WAYS-1:0]   drt;
   logic [AW-1:0]     age  [WAYS];
   logic [AW-1:0]     age_n[WAYS];
   logic [AWID-1:0]   tags [WAYS];
   logic              hit;
   logic              found;
   logic [WW-1:0]     hit_way;
   logic              has_empty;
   logic [WW-1:0]     empty_way;
   logic [WW-1:0]     lru_way;
   logic [AW-1:0]     best_age;
   logic [WW-1:0]     tgt;
   logic              wb;
   logic              was_valid;
   logic [AW-1:0]     old_age;

   always_comb begin
      found     = 1'b0;
      hit_way   = '0;
      has_empty = 1'b0;
      empty_way = '0;
      lru_way   = '0;
      for (int w = 0; w < WAYS; w++) begin
         vld[w]  = meta_rd[w*META_W];
         drt[w]  = meta_rd[w*META_W + 1];
         age[w]  = meta_rd[w*META_W + 2 +: AW];
         tags[w] = tag_rd[w*AWID +: AWID];
      end
      best_age = age[0];
      for (int w = 0; w < WAYS; w++) begin
         if (!found && vld[w] && (tags[w] == tag_ff)) begin
            found   = 1'b1;
            hit_way = WW'(w);
         end
         if (!has_empty && !vld[w]) begin
            has_empty = 1'b1;
            empty_way = WW'(w);
         end
      end
      for (int w = 1; w < WAYS; w++) begin
         if (age[w] > best_age) begin
            best_age = age[w];
            lru_way  = WW'(w);
         end
      end
      hit       = found;
      tgt       = hit ? hit_way : (has_empty ? empty_way : lru_way);
      wb        = !hit && !has_empty && drt[tgt];
      was_valid = vld[tgt];
      old_age   = age[tgt];

      // Move the target way to most recent; valid ways more recent than it (all valid ways on a fill) age by one.
      for (int w = 0; w < WAYS; w++) begin
         age_n[w] = age[w];
         if (WW'(w) == tgt) begin
            age_n[w] = '0;
         end else if (vld[w] && (!was_valid || (age[w] < old_age))) begin
            age_n[w] = age[w] + AW'(1);
         end
      end

      // New rows.
      tag_wr  = tag_rd;
      meta_wr = '0;
      for (int w = 0; w < WAYS; w++) begin
         meta_wr[w*META_W + 2 +: AW] = age_n[w];
         meta_wr[w*META_W]           = vld[w];
         meta_wr[w*META_W + 1]       = drt[w];
         if (WW'(w) == tgt) begin
            meta_wr[w*META_W] = 1'b1;
            if (hit) begin
               meta_wr[w*META_W + 1] = drt[w] | (cmd_ff == salwc_pkg::CMD_WRITE);
            end else begin
               meta_wr[w*META_W + 1] = (cmd_ff == salwc_pkg::CMD_WRITE);
               tag_wr[w*AWID +: AWID] = tag_ff;
            end
         end
      end
   end

   // Event counters.
   logic [CW-1:0] cnt_ff [salwc_pkg::NUM_CNT];
   logic [CW-1:0] cnt_in [salwc_pkg::NUM_CNT];
   logic          is_wr;

   always_comb begin
      is_wr = (cmd_ff == salwc_pkg::CMD_WRITE);
      cnt_in[salwc_pkg::CNT_ACCESS] = salwc_pkg::sat_inc(cnt_ff[salwc_pkg::CNT_ACCESS], 1'b1);
      cnt_in[salwc_pkg::CNT_READ]   = salwc_pkg::sat_inc(cnt_ff[salwc_pkg::CNT_READ], !is_wr);
      cnt_in[salwc_pkg::CNT_WRITE]  = salwc_pkg::sat_inc(cnt_ff[salwc_pkg::CNT_WRITE], is_wr);
      cnt_in[salwc_pkg::CNT_RMISS]  = salwc_pkg::sat_inc(cnt_ff[salwc_pkg::CNT_RMISS],
                                                         !hit && !is_wr);
      cnt_in[salwc_pkg::CNT_WMISS]  = salwc_pkg::sat_inc(cnt_ff[salwc_pkg::CNT_WMISS],
                                                         !hit && is_wr);
      cnt_in[salwc_pkg::CNT_WB]     = salwc_pkg::sat_inc(cnt_ff[salwc_pkg::CNT_WB], wb);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < salwc_pkg::NUM_CNT; i++) begin
            cnt_ff[i] <= '0;
         end
      end else if (cmd.update) begin
         for (int i = 0; i < salwc_pkg::NUM_CNT; i++) begin
            cnt_ff[i] <= cnt_in[i];
         end
      end
   end

   // Result register.
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   salwc_pkg::rsp_payload_type rsp_ff;

   assign rsp_valid_in = cmd.update ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rsp_ff.hit              <= hit;
         rsp_ff.way              <= 2'(tgt);
         rsp_ff.filled_empty     <= !hit && has_empty;
         rsp_ff.write_back       <= wb;
         rsp_ff.access_count     <= cnt_in[salwc_pkg::CNT_ACCESS];
         rsp_ff.read_count       <= cnt_in[salwc_pkg::CNT_READ];
         rsp_ff.write_count      <= cnt_in[salwc_pkg::CNT_WRITE];
         rsp_ff.read_miss_count  <= cnt_in[salwc_pkg::CNT_RMISS];
         rsp_ff.write_miss_count <= cnt_in[salwc_pkg::CNT_WMISS];
         rsp_ff.write_back_count <= cnt_in[salwc_pkg::CNT_WB];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Status back to the controller.
   assign status = '{clear_last: (clr_cnt_ff == SW'(SETS - 1)),
                     rsp_stall:  (rsp_valid_ff && !rsp_ready)};

endmodule

// ===== src/set_assoc_lru_writeback_cache_core.sv =====
// ----------------------------------------------------------------------------
// set_assoc_lru_writeback_cache_core
// Tag-only set-associative write-back, write-allocate cache with true LRU
// replacement and saturating event counters.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake             Payload
//  req_      in         req_valid/req_ready   req_data (cmd, address)
//  rsp_      out        rsp_valid/rsp_ready   rsp_data (hit, way, flags, counts)
//  csr_      in         csr_we                csr_index, csr_wdata
//
// Each access has an accept step, which reads the set's tag and metadata
// rows, and an update step, which writes them and loads the result register
// (read-modify-write of one set through the single read and write ports of
// the stores). After reset a clearing pass zeroes the metadata store; no
// request is taken meanwhile. A result waiting in the output register does
// not block the next request; the update step waits only if it is held.
// ----------------------------------------------------------------------------
module set_assoc_lru_writeback_cache_core #(
   parameter int WAYS = 4,
   parameter int SETS = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  salwc_pkg::req_payload_type  req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output salwc_pkg::rsp_payload_type  rsp_data,
   input  logic                        csr_we,
   input  logic                        csr_index,
   input  logic [salwc_pkg::CFG_W-1:0] csr_wdata
);

   salwc_pkg::ctrl_cmd_type    cmd;
   salwc_pkg::ctrl_status_type status;

   salwc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   salwc_datapath #(.WAYS(WAYS), .SETS(SETS)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

// ===== src/salwc_checker.sv =====
// ----------------------------------------------------------------------------
// salwc_checker
// Port-level checks of the cache core, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module salwc_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input salwc_pkg::rsp_payload_type rsp_data
);

   `CHK_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "result changed while held")
   `CHK_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result valid after reset")
   `CHK_ASSERT(a_hit_flags, clock, reset, rsp_valid && rsp_data.hit |-> !rsp_data.filled_empty && !rsp_data.write_back, "hit with fill or write-back")
   `CHK_ASSERT(a_count_sum, clock, reset, rsp_valid && (rsp_data.access_count != salwc_pkg::CNT_MAX) |-> rsp_data.access_count == rsp_data.read_count + rsp_data.write_count, "access count mismatch")

endmodule

bind set_assoc_lru_writeback_cache_core salwc_checker u_salwc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
